@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL files that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PTOM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define PTOM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/ptom_pkg.sv @@
// ----------------------------------------------------------------------------
// ptom_pkg: shared types and the priority function of the order matcher
// Order entry and trade layouts, book operation and request codes, result kinds, control states and priority rule.
// ----------------------------------------------------------------------------
`default_nettype none

package ptom_pkg;

    localparam int unsigned WordW = 32;

    typedef logic [WordW-1:0] word_t;

    // One resting order.
    typedef struct packed {
        word_t id;
        word_t price;
        word_t qty;
        word_t seq;
    } entry_t;

    // One trade waiting to be sent.
    typedef struct packed {
        word_t buy_id;
        word_t sell_id;
        word_t buy_limit;
        word_t sell_limit;
        word_t qty;
    } trade_t;

    // Operation applied to a book or to a single cell.
    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_INSERT = 2'd1,
        OP_POP    = 2'd2,
        OP_SETQ   = 2'd3
    } book_op_t;

    // Request codes.
    typedef enum logic [1:0] {
        REQ_BUY  = 2'd0,
        REQ_SELL = 2'd1,
        REQ_EXEC = 2'd2,
        REQ_NOP  = 2'd3
    } req_t;

    // Result kinds.
    localparam logic KIND_TRADE  = 1'b0;
    localparam logic KIND_REJECT = 1'b1;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_MATCH = 1'b1
    } state_t;

    // True if entry a has strict priority over entry b.
    function automatic logic better(input entry_t a, input entry_t b, input logic is_bid);
        logic res;
        if (a.price != b.price)
        begin
            res = is_bid ? (a.price > b.price) : (a.price < b.price);
        end
        else
        begin
            res = (a.seq < b.seq);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/ptom_cell.sv @@
// ----------------------------------------------------------------------------
// ptom_cell: one slot of a sorted order chain
// Holds one order; on insert it keeps, takes the new order or takes its
// upper neighbor; on pop it takes its lower neighbor; on a quantity update it replaces its quantity.
// ----------------------------------------------------------------------------
`default_nettype none

module ptom_cell #(
    parameter bit IS_BID = 1'b1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ptom_pkg::book_op_t op,
    input  wire ptom_pkg::entry_t  new_entry,
    input  wire ptom_pkg::word_t   new_qty,
    input  wire ptom_pkg::entry_t  prev_entry,
    input  wire logic              prev_valid,
    input  wire logic              prev_after,
    input  wire ptom_pkg::entry_t  next_entry,
    input  wire logic              next_valid,
    output      ptom_pkg::entry_t  entry,
    output      logic              valid,
    output      logic              after
);

    ptom_pkg::entry_t entry_reg;
    ptom_pkg::entry_t entry_next;
    logic             valid_reg;
    logic             valid_next;

    // The new order belongs at or above this slot.
    assign after = !valid_reg || ptom_pkg::better(new_entry, entry_reg, IS_BID);
    assign entry = entry_reg;
    assign valid = valid_reg;

    // Next slot contents.
    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        unique case (op)
            ptom_pkg::OP_INSERT:
            begin
                if (prev_after)
                begin
                    entry_next = prev_entry;
                    valid_next = prev_valid;
                end
                else if (after)
                begin
                    entry_next = new_entry;
                    valid_next = 1'b1;
                end
            end
            ptom_pkg::OP_POP:
            begin
                entry_next = next_entry;
                valid_next = next_valid;
            end
            ptom_pkg::OP_SETQ:
            begin
                entry_next.qty = new_qty;
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

`default_nettype wire

@@ rtl/ptom_book.sv @@
// ----------------------------------------------------------------------------
// ptom_book: one side of the book as a sorted chain of cells
// The head cell always holds the best order; the last cell marks full.
// ----------------------------------------------------------------------------
`default_nettype none

module ptom_book #(
    parameter int unsigned DEPTH  = 32,
    parameter bit          IS_BID = 1'b1
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ptom_pkg::book_op_t op,
    input  wire ptom_pkg::entry_t   new_entry,
    input  wire ptom_pkg::word_t    new_qty,
    output      ptom_pkg::entry_t   head,
    output      logic               head_valid,
    output      logic               full
);

    ptom_pkg::entry_t  cell_entry [DEPTH];
    logic              cell_valid [DEPTH];
    logic              cell_after [DEPTH];
    ptom_pkg::book_op_t rest_op;

    // Quantity updates touch only the head cell.
    assign rest_op = (op == ptom_pkg::OP_SETQ) ? ptom_pkg::OP_NONE : op;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            ptom_pkg::entry_t pe;
            logic             pv;
            logic             pa;
            ptom_pkg::entry_t ne;
            logic             nv;
            if (gi == 0)
            begin : g_first
                assign pe = new_entry;
                assign pv = 1'b0;
                assign pa = 1'b0;
            end
            else
            begin : g_mid
                assign pe = cell_entry[gi-1];
                assign pv = cell_valid[gi-1];
                assign pa = cell_after[gi-1];
            end
            if (gi == DEPTH - 1)
            begin : g_last
                assign ne = new_entry;
                assign nv = 1'b0;
            end
            else
            begin : g_inner
                assign ne = cell_entry[gi+1];
                assign nv = cell_valid[gi+1];
            end

            ptom_cell #(
                .IS_BID (IS_BID)
            ) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .op         ((gi == 0) ? op : rest_op),
                .new_entry  (new_entry),
                .new_qty    (new_qty),
                .prev_entry (pe),
                .prev_valid (pv),
                .prev_after (pa),
                .next_entry (ne),
                .next_valid (nv),
                .entry      (cell_entry[gi]),
                .valid      (cell_valid[gi]),
                .after      (cell_after[gi])
            );
        end
    endgenerate

    assign head       = cell_entry[0];
    assign head_valid = cell_valid[0];
    assign full       = cell_valid[DEPTH-1];

endmodule

`default_nettype wire

@@ rtl/price_time_order_matcher.sv @@
// Add: inserted, or a reject result appears in the output register next cycle.
// Execute: one trade per cycle from the two sorted cell chains unless the output stalls.
// Execute holds off new input until the heads stop crossing and the held trade is sent.
// Back-pressure on the output stalls matching; one held trade sits behind the output register.
// Reset (rst_n, asynchronous, active low) empties both books and clears the sequence counter.
// ----------------------------------------------------------------------------
// price_time_order_matcher: two-sided limit order book with price-time matching
// Bids and asks rest in sorted cell chains; execute crosses the heads.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module price_time_order_matcher #(
    parameter int unsigned MAX_ORDERS = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_ready,
    input  wire logic [1:0]  req_type,
    input  wire logic [31:0] order_id,
    input  wire logic [31:0] order_price,
    input  wire logic [31:0] order_quantity,
    output      logic        out_valid,
    input  wire logic        out_ready,
    output      logic        kind,
    output      logic [31:0] buy_id,
    output      logic [31:0] sell_id,
    output      logic [31:0] buy_limit,
    output      logic [31:0] sell_limit,
    output      logic [31:0] trade_quantity,
    output      logic        last
);

    ptom_pkg::state_t   state_reg, state_next;
    ptom_pkg::word_t    seq_reg, seq_next;
    ptom_pkg::trade_t   held_reg, held_next;
    logic               held_valid_reg, held_valid_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_kind_reg, out_kind_next;
    logic               out_last_reg, out_last_next;
    ptom_pkg::trade_t   out_reg, out_next;

    ptom_pkg::book_op_t bid_op, ask_op;
    ptom_pkg::entry_t   new_entry;
    ptom_pkg::word_t    bid_qty, ask_qty;
    ptom_pkg::entry_t   bid_head, ask_head;
    logic               bid_hv, ask_hv, bid_full, ask_full;
    logic               out_free, heads_cross, in_fire;
    ptom_pkg::word_t    match_q;
    ptom_pkg::trade_t   trade;

    ptom_book #(.DEPTH(MAX_ORDERS), .IS_BID(1'b1)) u_bids (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (bid_op),
        .new_entry  (new_entry),
        .new_qty    (bid_qty),
        .head       (bid_head),
        .head_valid (bid_hv),
        .full       (bid_full)
    );

    ptom_book #(.DEPTH(MAX_ORDERS), .IS_BID(1'b0)) u_asks (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (ask_op),
        .new_entry  (new_entry),
        .new_qty    (ask_qty),
        .head       (ask_head),
        .head_valid (ask_hv),
        .full       (ask_full)
    );

    // Head comparison and trade formation.
    assign out_free    = !out_valid_reg || out_ready;
    assign heads_cross = bid_hv && ask_hv && (bid_head.price >= ask_head.price);
    assign match_q     = (bid_head.qty < ask_head.qty) ? bid_head.qty : ask_head.qty;
    assign trade       = '{buy_id: bid_head.id, sell_id: ask_head.id,
                           buy_limit: bid_head.price, sell_limit: ask_head.price,
                           qty: match_q};
    assign new_entry   = '{id: order_id, price: order_price, qty: order_quantity, seq: seq_reg};
    assign bid_qty     = bid_head.qty - match_q;
    assign ask_qty     = ask_head.qty - match_q;
    assign in_ready    = (state_reg == ptom_pkg::ST_IDLE) && out_free;
    assign in_fire     = in_valid && in_ready;

    // Control: request intake and the match loop.
    always_comb
    begin
        state_next      = state_reg;
        seq_next        = seq_reg;
        held_next       = held_reg;
        held_valid_next = held_valid_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_kind_next   = out_kind_reg;
        out_last_next   = out_last_reg;
        out_next        = out_reg;
        bid_op          = ptom_pkg::OP_NONE;
        ask_op          = ptom_pkg::OP_NONE;
        unique case (state_reg)
            ptom_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (req_type)
                        ptom_pkg::REQ_BUY, ptom_pkg::REQ_SELL:
                        begin
                            if ((req_type == ptom_pkg::REQ_BUY) ? bid_full : ask_full)
                            begin
                                out_valid_next = 1'b1;
                                out_kind_next  = ptom_pkg::KIND_REJECT;
                                out_last_next  = 1'b1;
                                out_next       = '0;
                                out_next.buy_id = order_id;
                            end
                            else
                            begin
                                if (req_type == ptom_pkg::REQ_BUY)
                                begin
                                    bid_op = ptom_pkg::OP_INSERT;
                                end
                                else
                                begin
                                    ask_op = ptom_pkg::OP_INSERT;
                                end
                                seq_next = seq_reg + 1'b1;
                            end
                        end
                        ptom_pkg::REQ_EXEC:
                        begin
                            state_next = ptom_pkg::ST_MATCH;
                        end
                        default:
                        begin
                            state_next = ptom_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            ptom_pkg::ST_MATCH:
            begin
                if (heads_cross)
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = ptom_pkg::KIND_TRADE;
                            out_last_next  = 1'b0;
                            out_next       = held_reg;
                        end
                        held_next       = trade;
                        held_valid_next = 1'b1;
                        bid_op = (bid_qty == '0) ? ptom_pkg::OP_POP : ptom_pkg::OP_SETQ;
                        ask_op = (ask_qty == '0) ? ptom_pkg::OP_POP : ptom_pkg::OP_SETQ;
                    end
                end
                else if (!held_valid_reg)
                begin
                    state_next = ptom_pkg::ST_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = ptom_pkg::KIND_TRADE;
                    out_last_next   = 1'b1;
                    out_next        = held_reg;
                    held_valid_next = 1'b0;
                    state_next      = ptom_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ptom_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ptom_pkg::ST_IDLE;
            seq_reg        <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seq_reg        <= seq_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        held_reg     <= held_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
        out_reg      <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign kind           = out_kind_reg;
    assign last           = out_last_reg;
    assign buy_id         = out_reg.buy_id;
    assign sell_id        = out_reg.sell_id;
    assign buy_limit      = out_reg.buy_limit;
    assign sell_limit     = out_reg.sell_limit;
    assign trade_quantity = out_reg.qty;

    // A trade is held only while the match loop runs.
    `PTOM_ASSERT_IMPL(a_held_in_match, held_valid_reg, state_reg == ptom_pkg::ST_MATCH)
    // A reject is always the final result of its request.
    `PTOM_ASSERT_IMPL(a_reject_last, out_valid_reg && out_kind_reg, out_last_reg)
    // A held trade is never left behind when the loop closes.
    `PTOM_ASSERT_NEXT(a_close_flush,
        (state_reg == ptom_pkg::ST_MATCH) && !heads_cross && held_valid_reg && out_free,
        out_valid_reg && out_last_reg && !held_valid_reg)

endmodule

`default_nettype wire
